// File: rtl/chkv_pkg.sv
// shared constants, codes and helpers of the chained hash key-value table
package chkv_pkg;

   localparam int unsigned CAPACITY = 1024;
   localparam int unsigned BUCKETS  = 1024;
   localparam int unsigned IDX_W    = $clog2(CAPACITY);
   localparam int unsigned PTR_W    = IDX_W + 1;
   localparam int unsigned BKT_W    = $clog2(BUCKETS);
   localparam int unsigned KEY_W    = 64;
   localparam int unsigned VAL_W    = 64;
   localparam int unsigned LEN_W    = 4;
   localparam int unsigned VALUE_BYTES = 8;

   // invalid pointer marks the end of a chain
   localparam logic [PTR_W-1:0] NO_INDEX = PTR_W'(CAPACITY);

   // murmur3 x86_32 constants
   localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2 = 32'h1b873593;
   localparam logic [31:0] MM_C3 = 32'he6546b64;
   localparam logic [31:0] MM_F1 = 32'h85ebca6b;
   localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
   localparam logic [31:0] MM_KEY_LEN = 32'd8;

   // actions
   localparam logic [1:0] ACT_PUT = 2'd0;
   localparam logic [1:0] ACT_GET = 2'd1;
   localparam logic [1:0] ACT_DEL = 2'd2;
   localparam logic [1:0] ACT_BAD = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ERR  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // byte mask covering the low n bytes
   function automatic logic [VAL_W-1:0] bytes_mask(input logic [LEN_W-1:0] n);
      logic [VAL_W-1:0] m;
      for (int i = 0; i < VAL_W / 8; i++) begin
         m[i*8 +: 8] = (32'(n) > i) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
      return (x << r) | (x >> (32 - r));
   endfunction

endpackage

// File: rtl/chained_hash_kv_table_unit.sv
// chained hash key-value table: murmur3 hash, chain walk and pool update sequencer
// A request walks the hash states, then visits the chain one entry at a time; a put
// of a new key adds the free-stack pop and link states. The hash is computed by
// a chain of states that share one 32-bit multiplier, and each chain step
// costs one read of the entry pool memory. After reset the block steps through
// every entry index, clearing the bucket heads, values, lengths and the free stack before
// it takes its first request; the configuration register is writable at any time.
module chained_hash_kv_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [chkv_pkg::KEY_W-1:0]    req_key,
   input  logic [chkv_pkg::VAL_W-1:0]    req_value,
   input  logic                          req_value_present,
   input  logic [chkv_pkg::LEN_W-1:0]    req_value_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [chkv_pkg::VAL_W-1:0]    rsp_value_out,
   output logic [chkv_pkg::LEN_W-1:0]    rsp_stored_length,
   output logic [chkv_pkg::PTR_W-1:0]    rsp_entries_used,
   input  logic                          csr_write_enable,
   input  logic [chkv_pkg::LEN_W-1:0]    csr_write_data
);

   localparam int unsigned IDX_W = chkv_pkg::IDX_W;
   localparam int unsigned PTR_W = chkv_pkg::PTR_W;
   localparam int unsigned BKT_W = chkv_pkg::BKT_W;
   localparam int unsigned VAL_W = chkv_pkg::VAL_W;
   localparam int unsigned KEY_W = chkv_pkg::KEY_W;
   localparam int unsigned LEN_W = chkv_pkg::LEN_W;

   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_HK1  = 5'd2;
   localparam logic [4:0] S_HK2  = 5'd3;
   localparam logic [4:0] S_HH1  = 5'd4;
   localparam logic [4:0] S_HK3  = 5'd5;
   localparam logic [4:0] S_HH2  = 5'd6;
   localparam logic [4:0] S_HF1  = 5'd7;
   localparam logic [4:0] S_HF2  = 5'd8;
   localparam logic [4:0] S_HF3  = 5'd9;
   localparam logic [4:0] S_HEAD = 5'd10;
   localparam logic [4:0] S_CMP  = 5'd11;
   localparam logic [4:0] S_EXEC = 5'd12;
   localparam logic [4:0] S_POP  = 5'd13;
   localparam logic [4:0] S_POPW = 5'd14;
   localparam logic [4:0] S_WRV  = 5'd15;
   localparam logic [4:0] S_RESP = 5'd16;

   // memories
   logic [PTR_W-1:0] head_mem [chkv_pkg::BUCKETS];
   logic [KEY_W-1:0] key_mem  [chkv_pkg::CAPACITY];
   logic [VAL_W-1:0] val_mem  [chkv_pkg::CAPACITY];
   logic [LEN_W-1:0] len_mem  [chkv_pkg::CAPACITY];
   logic [PTR_W-1:0] next_mem [chkv_pkg::CAPACITY];
   logic [IDX_W-1:0] free_mem [chkv_pkg::CAPACITY];

   logic [4:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [LEN_W-1:0] maxlen_ff;
   logic [1:0]       act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] wval_ff, wval_in;
   logic             pres_ff, pres_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [31:0]      h_ff, h_in, k_ff, k_in;
   logic [BKT_W-1:0] bkt_ff, bkt_in;
   logic [PTR_W-1:0] head_ff, head_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [PTR_W-1:0] steps_ff, steps_in;
   logic             found_ff, found_in;
   logic [PTR_W-1:0] free_cnt_ff, free_cnt_in, used_ff, used_in;
   logic [1:0]       res_st_ff, res_st_in;
   logic [VAL_W-1:0] res_val_ff, res_val_in;
   logic [LEN_W-1:0] res_len_ff, res_len_in;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic [PTR_W-1:0] rsp_used_ff;

   // memory ports
   logic [BKT_W-1:0] head_ra, head_wa;
   logic             head_we;
   logic [PTR_W-1:0] head_wd, head_rd;
   logic [IDX_W-1:0] ent_ra;
   logic [KEY_W-1:0] key_rd;
   logic [VAL_W-1:0] val_rd, val_wd;
   logic [LEN_W-1:0] len_rd, len_wd;
   logic [PTR_W-1:0] next_rd, next_wd;
   logic             key_we, val_we, next_we, free_we;
   logic [IDX_W-1:0] key_wa, val_wa, next_wa, free_wa, free_ra, free_wd, free_rd;
   logic             load_rsp;
   logic [31:0]      t_rot, t_mul;
   logic [LEN_W-1:0] limit, take_len;

   assign limit    = (maxlen_ff < LEN_W'(chkv_pkg::VALUE_BYTES)) ? maxlen_ff
                                                             : LEN_W'(chkv_pkg::VALUE_BYTES);
   assign take_len = (len_ff < len_rd) ? len_ff : len_rd;
   assign req_ready = (state_ff == S_IDLE);
   assign load_rsp  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // operands of the shared multiplier
   always_comb begin
      t_rot = 32'd0;
      t_mul = 32'd0;
      unique case (state_ff)
         S_HK1:        begin t_rot = key_ff[31:0];  t_mul = chkv_pkg::MM_C1; end
         S_HK2, S_HK3: begin t_rot = chkv_pkg::rotl32(k_ff, 15); t_mul = chkv_pkg::MM_C2; end
         S_HH1:        begin t_rot = key_ff[63:32]; t_mul = chkv_pkg::MM_C1; end
         S_HF1:        begin t_rot = h_ff ^ (h_ff >> 16); t_mul = chkv_pkg::MM_F1; end
         S_HF2:        begin t_rot = h_ff ^ (h_ff >> 13); t_mul = chkv_pkg::MM_F2; end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      logic [31:0] hr;
      logic [VAL_W-1:0] m;
      state_in = state_ff;  clr_in = clr_ff;
      act_in = act_ff;  key_in = key_ff;  wval_in = wval_ff;
      pres_in = pres_ff;  len_in = len_ff;
      h_in = h_ff;  k_in = k_ff;  bkt_in = bkt_ff;
      head_in = head_ff;  cur_in = cur_ff;  prev_in = prev_ff;
      steps_in = steps_ff;  found_in = found_ff;
      free_cnt_in = free_cnt_ff;  used_in = used_ff;
      res_st_in = res_st_ff;  res_val_in = res_val_ff;  res_len_in = res_len_ff;
      head_ra = bkt_ff;  head_we = 1'b0;  head_wa = bkt_ff;  head_wd = chkv_pkg::NO_INDEX;
      ent_ra = cur_ff[IDX_W-1:0];
      key_we = 1'b0;  key_wa = cur_ff[IDX_W-1:0];
      val_we = 1'b0;  val_wa = cur_ff[IDX_W-1:0];  val_wd = '0;  len_wd = '0;
      next_we = 1'b0; next_wa = cur_ff[IDX_W-1:0]; next_wd = head_ff;
      free_we = 1'b0; free_wa = free_cnt_ff[IDX_W-1:0]; free_wd = cur_ff[IDX_W-1:0];
      free_ra = free_cnt_ff[IDX_W-1:0] - IDX_W'(1);
      hr = chkv_pkg::rotl32(h_ff ^ k_ff, 13);
      m  = chkv_pkg::bytes_mask(len_ff);
      unique case (state_ff)
         // clearing pass after reset
         S_CLR: begin
            head_we = 1'b1;  head_wa = clr_ff[BKT_W-1:0];  head_wd = chkv_pkg::NO_INDEX;
            val_we = 1'b1;   val_wa = clr_ff;  val_wd = '0;  len_wd = '0;
            free_we = 1'b1;  free_wa = clr_ff;  free_wd = clr_ff;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(chkv_pkg::CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         // take a request, reject bad ones at once
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action;  key_in = req_key;  wval_in = req_value;
               pres_in = req_value_present;  len_in = req_value_length;
               res_val_in = '0;  res_len_in = '0;  res_st_in = chkv_pkg::ST_ERR;
               h_in = 32'd0;
               if (req_action == chkv_pkg::ACT_BAD ||
                   (req_action == chkv_pkg::ACT_PUT && req_value_length > limit)) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_HK1;
               end
            end
         end
         // murmur3 rounds through the shared multiplier
         S_HK1: begin k_in = t_rot * t_mul; state_in = S_HK2; end
         S_HK2: begin k_in = t_rot * t_mul; state_in = S_HH1; end
         S_HH1: begin
            h_in = hr * 32'd5 + chkv_pkg::MM_C3;
            k_in = t_rot * t_mul;
            state_in = S_HK3;
         end
         S_HK3: begin k_in = t_rot * t_mul; state_in = S_HH2; end
         S_HH2: begin
            h_in = (hr * 32'd5 + chkv_pkg::MM_C3) ^ chkv_pkg::MM_KEY_LEN;
            state_in = S_HF1;
         end
         S_HF1: begin h_in = t_rot * t_mul; state_in = S_HF2; end
         S_HF2: begin h_in = t_rot * t_mul; state_in = S_HF3; end
         S_HF3: begin
            bkt_in  = BKT_W'(h_ff ^ (h_ff >> 16));
            head_ra = bkt_in;
            state_in = S_HEAD;
         end
         // bucket head arrives, start the walk
         S_HEAD: begin
            head_in = head_rd;  cur_in = head_rd;  prev_in = chkv_pkg::NO_INDEX;
            steps_in = '0;  found_in = 1'b0;
            ent_ra = head_rd[IDX_W-1:0];
            state_in = head_rd[IDX_W] ? S_EXEC : S_CMP;
         end
         // chain step: compare key, follow next
         S_CMP: begin
            if (key_rd == key_ff) begin
               found_in = 1'b1;
               state_in = S_EXEC;
            end else if (steps_ff == PTR_W'(chkv_pkg::CAPACITY - 1) || next_rd[IDX_W]) begin
               state_in = S_EXEC;
            end else begin
               prev_in = cur_ff;  cur_in = next_rd;  steps_in = steps_ff + PTR_W'(1);
               ent_ra = next_rd[IDX_W-1:0];
            end
         end
         // apply the action
         S_EXEC: begin
            state_in = S_RESP;
            case (act_ff)
               chkv_pkg::ACT_PUT: begin
                  if (found_ff) begin
                     state_in = S_WRV;
                  end else if (free_cnt_ff == '0) begin
                     res_st_in = chkv_pkg::ST_FULL;
                  end else begin
                     state_in = S_POP;
                  end
               end
               chkv_pkg::ACT_GET: begin
                  if (found_ff) begin
                     res_st_in = chkv_pkg::ST_OK;
                     res_val_in = val_rd & chkv_pkg::bytes_mask(take_len);
                     res_len_in = len_rd;
                  end
               end
               default: begin
                  if (found_ff) begin
                     if (prev_ff[IDX_W]) begin
                        head_we = 1'b1;  head_wd = next_rd;
                     end else begin
                        next_we = 1'b1;  next_wa = prev_ff[IDX_W-1:0];  next_wd = next_rd;
                     end
                     if (free_cnt_ff < PTR_W'(chkv_pkg::CAPACITY)) begin
                        free_we = 1'b1;
                        free_cnt_in = free_cnt_ff + PTR_W'(1);
                     end
                     if (used_ff != '0) begin
                        used_in = used_ff - PTR_W'(1);
                     end
                     res_st_in = chkv_pkg::ST_OK;
                  end
               end
            endcase
         end
         // pop a free entry
         S_POP: begin
            free_cnt_in = free_cnt_ff - PTR_W'(1);
            state_in = S_POPW;
         end
         // link the new entry at the chain head
         S_POPW: begin
            cur_in = {1'b0, free_rd};
            ent_ra = free_rd;
            key_we = 1'b1;   key_wa = free_rd;
            next_we = 1'b1;  next_wa = free_rd;  next_wd = head_ff;
            head_we = 1'b1;  head_wd = {1'b0, free_rd};
            used_in = used_ff + PTR_W'(1);
            state_in = S_WRV;
         end
         // merge value bytes and length
         S_WRV: begin
            val_we = 1'b1;
            val_wd = pres_ff ? ((val_rd & ~m) | (wval_ff & m)) : val_rd;
            len_wd = len_ff;
            res_st_in = chkv_pkg::ST_OK;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory arrays
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd <= head_mem[head_ra];
      if (key_we) key_mem[key_wa] <= key_ff;
      key_rd <= key_mem[ent_ra];
      if (val_we) begin
         val_mem[val_wa] <= val_wd;
         len_mem[val_wa] <= len_wd;
      end
      val_rd <= val_mem[ent_ra];
      len_rd <= len_mem[ent_ra];
      if (next_we) next_mem[next_wa] <= next_wd;
      next_rd <= next_mem[ent_ra];
      if (free_we) free_mem[free_wa] <= free_wd;
      free_rd <= free_mem[free_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLR;
         clr_ff      <= '0;
         maxlen_ff   <= LEN_W'(8);
         free_cnt_ff <= PTR_W'(chkv_pkg::CAPACITY);
         used_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         free_cnt_ff <= free_cnt_in;
         used_ff     <= used_in;
         if (csr_write_enable) maxlen_ff <= csr_write_data;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff <= act_in;  key_ff <= key_in;  wval_ff <= wval_in;
      pres_ff <= pres_in;  len_ff <= len_in;
      h_ff <= h_in;  k_ff <= k_in;  bkt_ff <= bkt_in;
      head_ff <= head_in;  cur_ff <= cur_in;  prev_ff <= prev_in;
      steps_ff <= steps_in;  found_ff <= found_in;
      res_st_ff <= res_st_in;  res_val_ff <= res_val_in;  res_len_ff <= res_len_in;
      if (load_rsp) begin
         rsp_status_ff <= res_st_ff;
         rsp_value_ff  <= res_val_ff;
         rsp_len_ff    <= res_len_ff;
         rsp_used_ff   <= used_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_value_out     = rsp_value_ff;
   assign rsp_stored_length = rsp_len_ff;
   assign rsp_entries_used  = rsp_used_ff;

endmodule

// File: tb/chkv_checker.sv
// response checker: watches both channels, predicts the table behavior and compares
module chkv_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [chkv_pkg::KEY_W-1:0]    req_key,
   input  logic [chkv_pkg::VAL_W-1:0]    req_value,
   input  logic                          req_value_present,
   input  logic [chkv_pkg::LEN_W-1:0]    req_value_length,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_status,
   input  logic [chkv_pkg::VAL_W-1:0]    rsp_value_out,
   input  logic [chkv_pkg::LEN_W-1:0]    rsp_stored_length,
   input  logic [chkv_pkg::PTR_W-1:0]    rsp_entries_used,
   input  logic                          csr_write_enable,
   input  logic [chkv_pkg::LEN_W-1:0]    csr_write_data,
   output int                            error_count,
   output int                            pending_count,
   output int                            response_count
);

   typedef struct packed {
      logic [1:0]                 status;
      logic [chkv_pkg::VAL_W-1:0] value_out;
      logic [chkv_pkg::LEN_W-1:0] stored_length;
      logic [chkv_pkg::PTR_W-1:0] entries_used;
   } kv_response_type;

   kv_response_type             expected_responses[$];
   logic [chkv_pkg::PTR_W-1:0]  head_ptr[chkv_pkg::BUCKETS];
   logic [chkv_pkg::KEY_W-1:0]  pool_key[chkv_pkg::CAPACITY];
   logic [chkv_pkg::VAL_W-1:0]  pool_value[chkv_pkg::CAPACITY];
   logic [chkv_pkg::LEN_W-1:0]  pool_length[chkv_pkg::CAPACITY];
   logic [chkv_pkg::PTR_W-1:0]  pool_next[chkv_pkg::CAPACITY];
   logic [chkv_pkg::IDX_W-1:0]  spare_slots[chkv_pkg::CAPACITY];
   int unsigned                 free_depth;
   int unsigned                 occupied;
   logic [chkv_pkg::LEN_W-1:0]  length_limit;

   function automatic logic [63:0] low_bytes(input int unsigned n);
      return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
   endfunction

   function automatic logic [31:0] scramble(input logic [31:0] k);
      k = k * chkv_pkg::MM_C1;
      k = (k << 15) | (k >> 17);
      return k * chkv_pkg::MM_C2;
   endfunction

   function automatic logic [31:0] key_hash(input logic [63:0] key);
      logic [31:0] h;
      h = 32'd0;
      for (int i = 0; i < 2; i++) begin
         h ^= scramble(key[32*i +: 32]);
         h = (h << 13) | (h >> 19);
         h = h * 32'd5 + chkv_pkg::MM_C3;
      end
      h ^= 32'd8;
      h ^= h >> 16;
      h = h * chkv_pkg::MM_F1;
      h ^= h >> 13;
      h = h * chkv_pkg::MM_F2;
      h ^= h >> 16;
      return h;
   endfunction

   // apply one request to the table copy and return the response it yields
   function automatic kv_response_type apply_request(input logic [1:0] action,
         input logic [63:0] key, input logic [63:0] value, input logic present,
         input logic [3:0] len);
      kv_response_type rsp;
      int unsigned     bucket, prev, cur, idx, lim, copy;
      logic [63:0]     m;
      rsp = '0;
      rsp.status = chkv_pkg::ST_ERR;
      bucket = key_hash(key) % chkv_pkg::BUCKETS;
      prev = chkv_pkg::CAPACITY;
      cur = head_ptr[bucket];
      lim = (length_limit < chkv_pkg::VALUE_BYTES) ? length_limit : chkv_pkg::VALUE_BYTES;
      if (action == chkv_pkg::ACT_BAD || (action == chkv_pkg::ACT_PUT && len > lim)) begin
         rsp.entries_used = chkv_pkg::PTR_W'(occupied);
         return rsp;
      end
      // chain walk
      while (cur < chkv_pkg::CAPACITY && pool_key[cur] != key) begin
         prev = cur;
         cur = pool_next[cur];
      end
      case (action)
         chkv_pkg::ACT_PUT: begin
            idx = cur;
            if (idx >= chkv_pkg::CAPACITY) begin
               if (free_depth == 0) begin
                  rsp.status = chkv_pkg::ST_FULL;
               end else begin
                  free_depth--;
                  idx = spare_slots[free_depth];
                  pool_key[idx] = key;
                  pool_next[idx] = head_ptr[bucket];
                  head_ptr[bucket] = chkv_pkg::PTR_W'(idx);
                  occupied++;
               end
            end
            if (idx < chkv_pkg::CAPACITY) begin
               m = low_bytes(len);
               if (present) pool_value[idx] = (pool_value[idx] & ~m) | (value & m);
               pool_length[idx] = len;
               rsp.status = chkv_pkg::ST_OK;
            end
         end
         chkv_pkg::ACT_GET: begin
            if (cur < chkv_pkg::CAPACITY) begin
               copy = (len < pool_length[cur]) ? len : pool_length[cur];
               rsp.value_out = pool_value[cur] & low_bytes(copy);
               rsp.stored_length = pool_length[cur];
               rsp.status = chkv_pkg::ST_OK;
            end
         end
         default: begin
            if (cur < chkv_pkg::CAPACITY) begin
               if (prev >= chkv_pkg::CAPACITY) head_ptr[bucket] = pool_next[cur];
               else pool_next[prev] = pool_next[cur];
               if (free_depth < chkv_pkg::CAPACITY) begin
                  spare_slots[free_depth] = chkv_pkg::IDX_W'(cur);
                  free_depth++;
               end
               if (occupied > 0) occupied--;
               rsp.status = chkv_pkg::ST_OK;
            end
         end
      endcase
      rsp.entries_used = chkv_pkg::PTR_W'(occupied);
      return rsp;
   endfunction

   // predict on accepted requests, compare accepted responses
   always @(posedge clock) begin
      kv_response_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < chkv_pkg::BUCKETS; i++) head_ptr[i] = chkv_pkg::NO_INDEX;
         for (int i = 0; i < chkv_pkg::CAPACITY; i++) begin
            pool_key[i] = '0;
            pool_value[i] = '0;
            pool_length[i] = '0;
            pool_next[i] = chkv_pkg::NO_INDEX;
            spare_slots[i] = chkv_pkg::IDX_W'(i);
         end
         free_depth = chkv_pkg::CAPACITY;
         occupied = 0;
         length_limit = 4'd8;
         expected_responses.delete();
         error_count <= 0;
         response_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_write_enable) length_limit = csr_write_data;
         if (req_valid && req_ready)
            expected_responses.push_back(apply_request(req_action, req_key, req_value,
                  req_value_present, req_value_length));
         if (rsp_valid && rsp_ready) begin
            response_count <= response_count + 1;
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response status=%0d", $time, rsp_status);
               error_count <= error_count + 1;
            end else begin
               exp_rsp = expected_responses.pop_front();
               if (exp_rsp.status !== rsp_status ||
                     exp_rsp.value_out !== rsp_value_out ||
                     exp_rsp.stored_length !== rsp_stored_length ||
                     exp_rsp.entries_used !== rsp_entries_used) begin
                  $display("%0t: mismatch expected st=%0d val=%h len=%0d used=%0d",
                        $time, exp_rsp.status, exp_rsp.value_out,
                        exp_rsp.stored_length, exp_rsp.entries_used);
                  $display("%0t:          actual   st=%0d val=%h len=%0d used=%0d",
                        $time, rsp_status, rsp_value_out, rsp_stored_length,
                        rsp_entries_used);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= expected_responses.size();
      end
   end
endmodule

// File: tb/tb_top.sv
// testbench top: clock, reset, request stimulus, config phases and verdict
module tb_top;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_action = chkv_pkg::ACT_PUT;
   logic [chkv_pkg::KEY_W-1:0] req_key = '0;
   logic [chkv_pkg::VAL_W-1:0] req_value = '0;
   logic                       req_value_present = 1'b0;
   logic [chkv_pkg::LEN_W-1:0] req_value_length = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_status;
   logic [chkv_pkg::VAL_W-1:0] rsp_value_out;
   logic [chkv_pkg::LEN_W-1:0] rsp_stored_length;
   logic [chkv_pkg::PTR_W-1:0] rsp_entries_used;
   logic                       csr_write_enable = 1'b0;
   logic [chkv_pkg::LEN_W-1:0] csr_write_data = '0;
   int                         error_count, pending_count, response_count;
   logic [63:0]                key_pool[16];
   int                         puts_sent, gets_sent, dels_sent;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   chained_hash_kv_table_unit dut (.*);
   chkv_checker checker_i (.*);

   // response side inserts random ready stalls between responses
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(3);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // valid stays up into the next request when there is no idle gap
   task automatic send_request(input logic [1:0] action, input logic [63:0] key,
         input logic [63:0] value, input logic present, input logic [3:0] len);
      int gap;
      gap = $urandom_range(3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_key <= key;
      req_value <= value;
      req_value_present <= present;
      req_value_length <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (action == chkv_pkg::ACT_PUT) puts_sent++;
      else if (action == chkv_pkg::ACT_GET) gets_sent++;
      else dels_sent++;
   endtask

   task automatic set_length_limit(input logic [3:0] limit);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(input int count);
      int sel;
      logic [1:0] act;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         act = (sel < 45) ? chkv_pkg::ACT_PUT : (sel < 75) ? chkv_pkg::ACT_GET :
               (sel < 97) ? chkv_pkg::ACT_DEL : chkv_pkg::ACT_BAD;
         send_request(act, ($urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(15)],
               rand64(), 1'($urandom), 4'($urandom_range(15) < 12 ? $urandom_range(8)
                                                                   : $urandom_range(15)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 16; i++) key_pool[i] = rand64();
      key_pool[0] = '0;
      key_pool[1] = '1;
      // directed: extremes, every action, long put, partial write, misses
      send_request(chkv_pkg::ACT_GET, 64'd0, '0, 1'b0, 4'd8);
      send_request(chkv_pkg::ACT_DEL, 64'd0, '0, 1'b0, 4'd0);
      send_request(chkv_pkg::ACT_PUT, 64'd0, '1, 1'b1, 4'd8);
      send_request(chkv_pkg::ACT_PUT, '1, '1, 1'b1, 4'd15);
      send_request(chkv_pkg::ACT_PUT, '1, 64'h0123456789abcdef, 1'b1, 4'd8);
      send_request(chkv_pkg::ACT_PUT, '1, '0, 1'b1, 4'd3);
      send_request(chkv_pkg::ACT_GET, '1, '0, 1'b0, 4'd15);
      send_request(chkv_pkg::ACT_PUT, '1, '0, 1'b0, 4'd6);
      send_request(chkv_pkg::ACT_GET, '1, '0, 1'b0, 4'd4);
      send_request(chkv_pkg::ACT_GET, 64'd0, '0, 1'b0, 4'd0);
      send_request(chkv_pkg::ACT_BAD, 64'd0, '1, 1'b1, 4'd15);
      send_request(chkv_pkg::ACT_DEL, '1, '0, 1'b0, 4'd0);
      send_request(chkv_pkg::ACT_GET, '1, '0, 1'b0, 4'd8);
      send_request(chkv_pkg::ACT_PUT, 64'h55aa55aa55aa55aa, '0, 1'b0, 4'd2);
      send_request(chkv_pkg::ACT_GET, 64'h55aa55aa55aa55aa, '0, 1'b0, 4'd8);
      send_request(chkv_pkg::ACT_DEL, 64'd0, '0, 1'b0, 4'd0);
      random_phase(250);
      set_length_limit(4'd0);
      random_phase(100);
      set_length_limit(4'd15);
      random_phase(150);
      set_length_limit(4'd3);
      random_phase(100);
      set_length_limit(4'd8);
      random_phase(280);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("ran %0d puts, %0d gets, %0d deletes/other, %0d responses checked",
            puts_sent, gets_sent, dels_sent, response_count);
      $display("limits 0/3/8/15 used, hits, misses, partial writes and bad actions mixed");
      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #800000;
      $display("timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
